// File: sv/bbc_pkg.sv
// Shared types, character codes and decode functions for the bracket balance checker.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    typedef enum logic [1:0] {
        BT_NONE   = 2'd0,
        BT_ROUND  = 2'd1,
        BT_SQUARE = 2'd2,
        BT_CURLY  = 2'd3
    } t_btype;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MISMATCH = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_UNCLOSED = 3'd3,
        ERR_OVERFLOW = 3'd4
    } t_err;

    typedef struct packed {
        logic   push;
        logic   pop;
        logic   clear;
        t_btype kind;
    } t_stack_op;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5b;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5d;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7b;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7d;

    function automatic t_btype open_type(input logic [7:0] b);
        t_btype t;
        unique case (b)
            CH_OPEN_ROUND:  t = BT_ROUND;
            CH_OPEN_SQUARE: t = BT_SQUARE;
            CH_OPEN_CURLY:  t = BT_CURLY;
            default:        t = BT_NONE;
        endcase
        return t;
    endfunction

    function automatic t_btype close_type(input logic [7:0] b);
        t_btype t;
        unique case (b)
            CH_CLOSE_ROUND:  t = BT_ROUND;
            CH_CLOSE_SQUARE: t = BT_SQUARE;
            CH_CLOSE_CURLY:  t = BT_CURLY;
            default:         t = BT_NONE;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: sv/bbc_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: sv/bbc_stack.sv
// Bracket type stack: cached top register, RAM for lower entries, prefetched entry below top.
`timescale 1ns / 1ps
`default_nettype none

module bbc_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire bbc_pkg::t_stack_op               i_op,
    output logic [$clog2(STACK_DEPTH+1)-1:0]      o_count,
    output bbc_pkg::t_btype                       o_top
);

    import bbc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [CW-1:0] r_count, n_count;
    t_btype        r_top, n_top;
    logic          r_fwd;
    t_btype        r_fwd_data;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [1:0]    rd_data;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] ncnt_m2;
    t_btype        below_top;

    assign cnt_m1  = r_count - CW'(1);
    assign ncnt_m2 = n_count - CW'(2);
    assign wr_addr = cnt_m1[AW-1:0];
    assign rd_addr = ncnt_m2[AW-1:0];
    assign wr_en   = i_op.push && (r_count != '0);

    // entry below top, bypassed when it was written in the same cycle it was read
    assign below_top = r_fwd ? r_fwd_data : t_btype'(rd_data);

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        if (i_op.push) begin
            n_count = r_count + CW'(1);
            n_top   = i_op.kind;
        end else if (i_op.pop) begin
            n_count = cnt_m1;
            n_top   = below_top;
        end
        if (i_op.clear) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_fwd   <= wr_en && (wr_addr == rd_addr);
        end
        r_top      <= n_top;
        r_fwd_data <= r_top;
    end

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_top),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_count = r_count;
    assign o_top   = r_top;

endmodule

`default_nettype wire

// File: sv/bracket_balance_checker_unit.sv
// Top level of the bracket balance checker: byte decode, sticky error, verdict output.
`timescale 1ns / 1ps
`default_nettype none

// Checks round, square and curly brackets in a byte stream, one byte per beat,
// tlast on the final byte of a text. Takes one beat every cycle; the verdict
// for a text appears on the master side the cycle after its last byte and the
// next text may start in that same cycle. The stack of STACK_DEPTH type codes
// lives in a single-port-read RAM; its top is held in a register and the entry
// below it is read every cycle, so a pop after a pop needs no wait. No clearing
// pass after reset. The slave side stalls only while a verdict is not taken.
module bracket_balance_checker_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata    // [0] balanced, [3:1] error_code, [7:4] zero
);

    import bbc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_stack_op     stk_op;
    logic [CW-1:0] stk_count;
    t_btype        stk_top;

    t_err   r_err, n_err;
    logic   r_m_valid, n_m_valid;
    logic   r_balanced, n_balanced;
    t_err   r_code, n_code;
    logic   accept;
    t_btype ot, ct;
    logic   empty_after;
    t_err   verdict;

    assign s_tready = !r_m_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign ot       = open_type(s_tdata);
    assign ct       = close_type(s_tdata);

    always_comb begin
        stk_op       = '0;
        stk_op.kind  = ot;
        n_err        = r_err;
        empty_after  = (stk_count == '0);
        verdict      = ERR_NONE;
        n_m_valid    = r_m_valid && !m_tready;
        n_balanced   = r_balanced;
        n_code       = r_code;
        if (accept) begin
            if (r_err == ERR_NONE) begin
                if (ot != BT_NONE) begin
                    if (stk_count == CW'(STACK_DEPTH)) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        stk_op.push = 1'b1;
                        empty_after = 1'b0;
                    end
                end else if (ct != BT_NONE) begin
                    if (stk_count == '0) begin
                        n_err = ERR_EMPTY;
                    end else begin
                        stk_op.pop  = 1'b1;
                        empty_after = (stk_count == CW'(1));
                        if (stk_top != ct) begin
                            n_err = ERR_MISMATCH;
                        end
                    end
                end
            end
            if (s_tlast) begin
                if (n_err != ERR_NONE) begin
                    verdict = n_err;
                end else if (!empty_after) begin
                    verdict = ERR_UNCLOSED;
                end
                n_m_valid    = 1'b1;
                n_balanced   = (verdict == ERR_NONE);
                n_code       = verdict;
                n_err        = ERR_NONE;
                stk_op.clear = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err     <= ERR_NONE;
            r_m_valid <= 1'b0;
        end else begin
            r_err     <= n_err;
            r_m_valid <= n_m_valid;
        end
        r_balanced <= n_balanced;
        r_code     <= n_code;
    end

    bbc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (stk_op),
        .o_count (stk_count),
        .o_top   (stk_top)
    );

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {4'b0000, r_code, r_balanced};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_verdict_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == 3'(ERR_NONE))))
        else $error("balanced flag disagrees with error code");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_tlast) |=> (m_tvalid && stk_count == '0 && r_err == ERR_NONE))
        else $error("state not cleared after last beat");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE && !(accept && s_tlast)) |=> (r_err == $past(r_err)))
        else $error("sticky error changed within a text");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Testbench for the bracket balance checker: directed and random texts checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import bbc_pkg::*;

    localparam int  DEPTH        = 64;
    localparam int  MAX_WAIT     = 17;
    localparam int  RANDOM_BEATS = 48;
    localparam int  TAIL_CYCLES  = 8;
    localparam int  CYCLE_LIMIT  = 500000;

    localparam int  IDLE_NONE  = 0;
    localparam int  IDLE_FULL  = 1;
    localparam int  IDLE_LIGHT = 2;

    localparam int  FAULT_NONE     = 0;
    localparam int  FAULT_SWAP     = 1;
    localparam int  FAULT_OPEN     = 2;
    localparam int  FAULT_CLOSE    = 3;
    localparam int  FAULT_SOUP     = 4;

    typedef struct {
        logic balanced;
        t_err code;
    } t_verdict;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    t_btype     type_stack [DEPTH];
    int         stack_depth;
    t_err       sticky_err;
    t_verdict   verdict_q [$];
    t_verdict   oldest;
    logic [7:0] txt_buf [$];

    int         mismatches;
    int         verdicts_seen;
    int         beats_sent;
    int         bracket_beats;
    int         texts_sent;
    int         code_hits [5];
    int         src_mode;
    int         snk_mode;
    longint     cycles;

    bracket_balance_checker_unit #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d verdicts pending", cycles, verdict_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // kind of bracket and whether it closes
    function automatic t_btype bracket_kind(input logic [7:0] b, output bit closing);
        closing = 1'b0;
        case (b)
            CH_OPEN_ROUND:   return BT_ROUND;
            CH_OPEN_SQUARE:  return BT_SQUARE;
            CH_OPEN_CURLY:   return BT_CURLY;
            CH_CLOSE_ROUND:  begin closing = 1'b1; return BT_ROUND;  end
            CH_CLOSE_SQUARE: begin closing = 1'b1; return BT_SQUARE; end
            CH_CLOSE_CURLY:  begin closing = 1'b1; return BT_CURLY;  end
            default:         return BT_NONE;
        endcase
    endfunction

    function automatic logic [7:0] bracket_char(input t_btype k, input bit closing);
        case (k)
            BT_ROUND:  return closing ? CH_CLOSE_ROUND  : CH_OPEN_ROUND;
            BT_SQUARE: return closing ? CH_CLOSE_SQUARE : CH_OPEN_SQUARE;
            default:   return closing ? CH_CLOSE_CURLY  : CH_OPEN_CURLY;
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        bit         c;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (bracket_kind(b, c) != BT_NONE);
        return b;
    endfunction

    function automatic t_btype random_kind();
        return t_btype'($urandom_range(1, 3));
    endfunction

    function automatic int draw_wait(input int mode);
        if (mode == IDLE_NONE)
            return 0;
        if (mode == IDLE_LIGHT && $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 20)
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // predictor: one accepted beat
    task automatic track_beat(input logic [7:0] b, input logic last);
        t_btype   kind;
        bit       closing;
        t_verdict v;
        kind = bracket_kind(b, closing);
        if (sticky_err == ERR_NONE && kind != BT_NONE) begin
            if (!closing) begin
                if (stack_depth >= DEPTH) begin
                    sticky_err = ERR_OVERFLOW;
                end else begin
                    type_stack[stack_depth] = kind;
                    stack_depth++;
                end
            end else if (stack_depth == 0) begin
                sticky_err = ERR_EMPTY;
            end else begin
                stack_depth--;
                if (type_stack[stack_depth] != kind)
                    sticky_err = ERR_MISMATCH;
            end
        end
        if (last) begin
            v.code = sticky_err;
            if (v.code == ERR_NONE && stack_depth != 0)
                v.code = ERR_UNCLOSED;
            v.balanced = (v.code == ERR_NONE);
            verdict_q.push_back(v);
            stack_depth = 0;
            sticky_err  = ERR_NONE;
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        bit c;
        gap = draw_wait(src_mode);
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        beats_sent++;
        if (bracket_kind(b, c) != BT_NONE)
            bracket_beats++;
        track_beat(b, last);
    endtask

    task automatic send_text();
        if (txt_buf.size() == 0)
            txt_buf.push_back(noise_byte());
        foreach (txt_buf[i])
            send_beat(txt_buf[i], i == txt_buf.size() - 1);
        texts_sent++;
        txt_buf.delete();
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            txt_buf.push_back(s[i]);
        send_text();
    endtask

    task automatic wait_verdicts_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_brackets(input int n, input bit closing, input t_btype k);
        repeat (n) txt_buf.push_back(bracket_char(k, closing));
    endtask

    // nested, matched brackets with optional noise between them
    task automatic build_nested(input int pairs, input int max_depth, input int noise_pct);
        t_btype open_q [$];
        t_btype k;
        int     left;
        left = pairs;
        while (left > 0 || open_q.size() > 0) begin
            if ($urandom_range(0, 99) < noise_pct)
                txt_buf.push_back(noise_byte());
            if (left > 0 && (open_q.size() == 0 ||
                             (open_q.size() < max_depth && $urandom_range(0, 1) == 1))) begin
                k = random_kind();
                open_q.push_back(k);
                txt_buf.push_back(bracket_char(k, 1'b0));
                left--;
            end else begin
                k = open_q.pop_back();
                txt_buf.push_back(bracket_char(k, 1'b1));
            end
        end
        if ($urandom_range(0, 3) == 0)
            txt_buf.push_back(noise_byte());
    endtask

    task automatic apply_fault(input int fault);
        int     idx_q [$];
        int     pos;
        t_btype k;
        bit     closing;
        case (fault)
            FAULT_SWAP: begin
                foreach (txt_buf[i]) begin
                    k = bracket_kind(txt_buf[i], closing);
                    if (k != BT_NONE && closing)
                        idx_q.push_back(i);
                end
                if (idx_q.size() > 0) begin
                    pos = idx_q[$urandom_range(0, idx_q.size() - 1)];
                    k   = bracket_kind(txt_buf[pos], closing);
                    txt_buf[pos] = bracket_char(t_btype'(((int'(k) % 3) + 1)), 1'b1);
                end
            end
            FAULT_OPEN: begin
                pos = $urandom_range(0, txt_buf.size());
                txt_buf.insert(pos, bracket_char(random_kind(), 1'b0));
            end
            FAULT_CLOSE: begin
                pos = $urandom_range(0, txt_buf.size());
                txt_buf.insert(pos, bracket_char(random_kind(), 1'b1));
            end
            FAULT_SOUP: begin
                txt_buf.delete();
                repeat ($urandom_range(1, 12)) begin
                    if ($urandom_range(0, 4) == 0)
                        txt_buf.push_back(noise_byte());
                    else
                        txt_buf.push_back(bracket_char(random_kind(),
                                                       1'($urandom_range(0, 1))));
                end
            end
            default: ;
        endcase
    endtask

    // sink: random stall before each verdict
    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            gap = draw_wait(snk_mode);
            @(negedge i_clk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict tdata=%02h with none pending", m_tdata));
            end else begin
                oldest = verdict_q.pop_front();
                code_hits[oldest.code]++;
                if (m_tdata[0] !== oldest.balanced)
                    report_mismatch($sformatf("verdict %0d balanced got %b exp %b",
                                              verdicts_seen, m_tdata[0], oldest.balanced));
                if (m_tdata[3:1] !== oldest.code)
                    report_mismatch($sformatf("verdict %0d error_code got %0d exp %0d",
                                              verdicts_seen, m_tdata[3:1], oldest.code));
                if (m_tdata[7:4] !== 4'd0)
                    report_mismatch($sformatf("verdict %0d pad bits got %h",
                                              verdicts_seen, m_tdata[7:4]));
            end
        end
    end

    task automatic test_directed();
        src_mode = IDLE_LIGHT;
        snk_mode = IDLE_LIGHT;
        send_str("([{}])");
        send_str("(]");
        send_str(")");
        send_str("((");
        txt_buf.push_back(8'h00);
        send_text();
        txt_buf.push_back(8'hff);
        send_text();
        send_str(")()");
        send_str("x(a)");
        wait_verdicts_drained();
    endtask

    task automatic test_stack_limits();
        src_mode = IDLE_NONE;
        snk_mode = IDLE_FULL;
        // exactly full, then emptied
        push_brackets(DEPTH, 1'b0, BT_SQUARE);
        push_brackets(DEPTH, 1'b1, BT_SQUARE);
        send_text();
        // one push past full
        push_brackets(DEPTH + 1, 1'b0, BT_ROUND);
        push_brackets(DEPTH + 1, 1'b1, BT_ROUND);
        send_text();
        // full and left open
        push_brackets(DEPTH, 1'b0, BT_CURLY);
        send_text();
        // full, wrong close at the top
        push_brackets(DEPTH, 1'b0, BT_CURLY);
        push_brackets(1, 1'b1, BT_ROUND);
        send_text();
        src_mode = IDLE_FULL;
        snk_mode = IDLE_NONE;
        build_nested(DEPTH, DEPTH, 10);
        send_text();
        wait_verdicts_drained();
    endtask

    task automatic test_back_to_back();
        src_mode = IDLE_NONE;
        snk_mode = IDLE_NONE;
        repeat (12) begin
            build_nested($urandom_range(0, 2), 2, 0);
            send_text();
        end
        snk_mode = IDLE_FULL;
        repeat (12) begin
            build_nested($urandom_range(0, 2), 2, 20);
            apply_fault($urandom_range(0, 1) ? FAULT_NONE : $urandom_range(FAULT_SWAP, FAULT_SOUP));
            send_text();
        end
        wait_verdicts_drained();
    endtask

    task automatic test_random_texts();
        int start;
        int fault;
        int pairs;
        bit deep;
        start = bracket_beats;
        while (bracket_beats - start < RANDOM_BEATS) begin
            if (texts_sent % 10 == 0) begin
                src_mode = $urandom_range(IDLE_NONE, IDLE_LIGHT);
                snk_mode = $urandom_range(IDLE_NONE, IDLE_LIGHT);
            end
            deep = ($urandom_range(0, 19) == 0);
            pairs = deep ? $urandom_range(DEPTH - 4, DEPTH + 2) : $urandom_range(0, 8);
            build_nested(pairs, deep ? DEPTH + 2 : $urandom_range(1, 6), $urandom_range(0, 40));
            fault = ($urandom_range(0, 9) < 7) ? FAULT_NONE
                                                : $urandom_range(FAULT_SWAP, FAULT_SOUP);
            apply_fault(fault);
            send_text();
            if (texts_sent % 25 == 0)
                wait_verdicts_drained();
        end
        wait_verdicts_drained();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        src_mode    = IDLE_NONE;
        snk_mode    = IDLE_NONE;
        stack_depth = 0;
        sticky_err  = ERR_NONE;
        foreach (type_stack[i]) type_stack[i] = BT_NONE;
        foreach (code_hits[i]) code_hits[i] = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_stack_limits();
        test_back_to_back();
        test_random_texts();

        wait_verdicts_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d texts in %0d beats (%0d brackets), %0d verdicts checked",
                 texts_sent, beats_sent, bracket_beats, verdicts_seen);
        $display("Verdicts: ok %0d, mismatch %0d, empty %0d, unclosed %0d, overflow %0d",
                 code_hits[ERR_NONE], code_hits[ERR_MISMATCH], code_hits[ERR_EMPTY],
                 code_hits[ERR_UNCLOSED], code_hits[ERR_OVERFLOW]);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
